### rtl/core/i2p_pkg.sv
// Shared types, character codes and the precedence function for the
// infix-to-postfix converter. No dependencies.
package i2p_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
    localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam logic [1:0] ST_CHAR      = 2'd0;
    localparam logic [1:0] ST_END       = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [2:0] {
        CMD_END,
        CMD_LETTER,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_OPER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  code;
        logic [2:0]  prec;
    } cmd_t;

    function automatic logic [2:0] prec_of(input logic [7:0] c);
        logic [2:0] p;
        case (c)
            CH_CARET:           p = 3'd4;
            CH_STAR, CH_SLASH:  p = 3'd3;
            CH_PLUS, CH_MINUS:  p = 3'd2;
            default:            p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/i2p_front.sv
// Front end: accepts input beats, classifies each character into a
// command and holds it in a two-entry queue for the stack engine. Uses i2p_pkg.
module i2p_front
    import i2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] char_code,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    cmd_t       fifo_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cls;
    logic       push, pop;

    always_comb
    begin
        cls.code = char_code;
        cls.prec = prec_of(char_code);
        if (func == FUNC_END)
            cls.kind = CMD_END;
        else if (char_code inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]})
            cls.kind = CMD_LETTER;
        else if (char_code == CH_LPAREN)
            cls.kind = CMD_OPEN;
        else if (char_code == CH_RPAREN)
            cls.kind = CMD_CLOSE;
        else
            cls.kind = CMD_OPER;
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = fifo_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### rtl/core/i2p_back.sv
// Back end: operator stack engine. Runs one queued command at a time,
// pops and emits postfix characters and markers through an output register.
// Uses i2p_pkg.
module i2p_back
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic [1:0] status,
    output logic       last
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FETCH,
        S_FETCH_DONE
    } state_t;

    typedef enum logic [2:0] {
        ACT_POP,
        ACT_MARK,
        ACT_PUSH,
        ACT_DROP,
        ACT_LETTER
    } act_t;

    logic [7:0]       stack_mem [STACK_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       top_reg, top_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_char_reg, pend_char_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic [1:0]       status_reg, status_next;
    logic             last_reg, last_next;

    act_t             act;
    logic [1:0]       mark_status;
    logic             out_free, can_pop, full, emit;

    assign out_free = !out_valid_reg || out_ready;
    assign can_pop  = (count_reg != '0) && (top_reg != CH_LPAREN);
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));

    // what the current command wants to do next
    always_comb
    begin
        act         = ACT_LETTER;
        mark_status = ST_END;
        case (cmd_reg.kind)
            CMD_END:
            begin
                act = (count_reg != '0) ? ACT_POP : ACT_MARK;
            end
            CMD_LETTER:
            begin
                act = ACT_LETTER;
            end
            CMD_OPEN:
            begin
                act         = full ? ACT_MARK : ACT_PUSH;
                mark_status = ST_OVERFLOW;
            end
            CMD_CLOSE:
            begin
                mark_status = ST_UNMATCHED;
                if (can_pop)
                    act = ACT_POP;
                else if (count_reg == '0)
                    act = ACT_MARK;
                else
                    act = ACT_DROP;
            end
            CMD_OPER:
            begin
                mark_status = ST_OVERFLOW;
                if (can_pop && (prec_of(top_reg) >= cmd_reg.prec))
                    act = ACT_POP;
                else
                    act = full ? ACT_MARK : ACT_PUSH;
            end
            default:
            begin
                act = ACT_LETTER;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        cmd_ready       = 1'b0;
        mem_we          = 1'b0;
        emit            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (pend_valid_reg)
                begin
                    // a popped char waits until we know whether more follows
                    if (out_free)
                    begin
                        emit          = 1'b1;
                        out_char_next = pend_char_reg;
                        status_next   = ST_CHAR;
                        last_next     = (act == ACT_PUSH) || (act == ACT_DROP);
                        case (act)
                            ACT_POP:
                            begin
                                pend_char_next = top_reg;
                                count_next     = count_reg - CNT_W'(1);
                                state_next     = S_FETCH;
                            end
                            ACT_PUSH:
                            begin
                                pend_valid_next = 1'b0;
                                mem_we          = 1'b1;
                                top_next        = cmd_reg.code;
                                count_next      = count_reg + CNT_W'(1);
                                state_next      = S_IDLE;
                            end
                            ACT_DROP:
                            begin
                                pend_valid_next = 1'b0;
                                count_next      = count_reg - CNT_W'(1);
                                state_next      = S_FETCH_DONE;
                            end
                            default:
                            begin
                                pend_valid_next = 1'b0;
                            end
                        endcase
                    end
                end
                else
                begin
                    case (act)
                        ACT_POP:
                        begin
                            pend_valid_next = 1'b1;
                            pend_char_next  = top_reg;
                            count_next      = count_reg - CNT_W'(1);
                            state_next      = S_FETCH;
                        end
                        ACT_MARK:
                        begin
                            if (out_free)
                            begin
                                emit          = 1'b1;
                                out_char_next = '0;
                                status_next   = mark_status;
                                last_next     = 1'b1;
                                count_next    = '0;
                                state_next    = S_IDLE;
                            end
                        end
                        ACT_PUSH:
                        begin
                            mem_we     = 1'b1;
                            top_next   = cmd_reg.code;
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_IDLE;
                        end
                        ACT_DROP:
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_FETCH_DONE;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                emit          = 1'b1;
                                out_char_next = cmd_reg.code;
                                status_next   = ST_CHAR;
                                last_next     = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                top_next   = rd_data_reg;
                state_next = S_RUN;
            end
            S_FETCH_DONE:
            begin
                top_next   = rd_data_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
    end

    // read the entry that becomes the new top; the read port is registered
    assign rd_addr = (count_next == '0) ? '0 : AW'(count_next - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[AW'(count_reg)] <= cmd_reg.code;
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            count_reg      <= '0;
            top_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            status_reg     <= ST_CHAR;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            status_reg     <= status_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_RUN || state_reg == S_FETCH))
        else $error("pending char outside a pop sequence");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_CHAR) |-> last_reg)
        else $error("marker beat not flagged last");

    a_ovf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && status_next == ST_OVERFLOW) |=> (count_reg == '0))
        else $error("stack not cleared after overflow");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result loaded over an untaken beat");

endmodule

### rtl/core/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: front end with command
// queue and the stack engine. Uses i2p_pkg, i2p_front, i2p_back.
//
// Usage:
//   Input channel (in_valid/in_ready, func, char_code): one beat per
//   expression character, or func=1 to end the expression and flush the
//   stack. Output channel (out_valid/out_ready, out_char, status, last):
//   postfix characters and marker beats; last flags the final beat caused
//   by one input beat. Inputs that only push produce no output beat.
//   Path: a letter's input beat goes through the command queue and the
//   command register (taken in S_IDLE) into the output register (S_RUN).
//   Command flow: each command passes through dispatch (S_IDLE) and
//   evaluation (S_RUN); every operator popped from the stack adds a pass
//   through S_FETCH, set by the registered read port of the stack memory,
//   and dropping a matched '(' adds one through S_FETCH_DONE. A two-entry
//   command queue lets input beats arrive while the engine is popping.
//   Reset: empties the queue and the stack and drops any pending output;
//   stack memory contents are not cleared and need no clearing pass.
//   Output stall: the output register holds its beat, the engine waits
//   at its next result, the queue fills and in_ready goes low.
module infix_to_postfix_converter
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic [1:0] status,
    output logic       last
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    i2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .char_code (char_code),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .status    (status),
        .last      (last)
    );

endmodule
